@@ hdl/lru_key_value_cache_macros.svh @@
// assertion macros for the lru key-value cache
// used by the top level only, no other dependencies
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// condition implies consequence in the same cycle
`define LKVC_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define LKVC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/lkvc_pkg.sv @@
// shared types and constants for the lru key-value cache
// no dependencies
package lkvc_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 31;
    localparam int RD_W     = 32;
    localparam int CAP_W    = 5;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int S_DATA_W = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RD_W + KEY_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

@@ hdl/lkvc_cell.sv @@
// one slot of the recency chain: key, value and valid bit
// depends on lkvc_pkg
module lkvc_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  lkvc_pkg::entry_t        up,
    input  logic [lkvc_pkg::KEY_W-1:0] cmp_key,
    output lkvc_pkg::entry_t        q,
    output logic                    match
);
    import lkvc_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= up.valid;
        end
    end

    // payload needs no reset, only read while valid
    always_ff @(posedge aclk) begin
        if (load) begin
            key_reg   <= up.key;
            value_reg <= up.value;
        end
    end

    assign q.valid = valid_reg;
    assign q.key   = key_reg;
    assign q.value = value_reg;
    assign match   = valid_reg && (key_reg == cmp_key);

endmodule

@@ hdl/lru_key_value_cache.sv @@
// top level of the lru key-value cache: control, capacity register, cell chain
// depends on lkvc_pkg, lkvc_cell and lru_key_value_cache_macros.svh
//
// usage
//   s_* carries requests: s_tuser is the action (0 get, 1 set), s_tdata holds
//   key in bits 31:0 and value in bits 62:32. m_* returns one result per
//   request: m_tuser holds found (bit 0) and evicted (bit 1), m_tdata holds
//   read_value in bits 31:0 and evicted_key in bits 63:32.
//   cfg_wr_en / cfg_wr_data write the capacity register (1..16, 0 acts as 1,
//   above 16 acts as 16); write only while no request is in flight.
// flow
//   a request is taken in idle, then looked up and applied in lookup once the
//   output register is free, and the result is registered onto m_*. the next
//   request is taken after the compare-and-shift pass over the chain of 16 cells
// reset
//   aresetn (synchronous, active low) empties the cache and sets capacity 16
// stall
//   a finished result waits in the output register while the next request is
//   taken; that request holds in lookup until the output register frees up
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lkvc_pkg::S_DATA_W-1:0]      s_tdata,  // key, value, zero pad
    input  logic                               s_tuser,  // action
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lkvc_pkg::M_DATA_W-1:0]      m_tdata,  // read_value, evicted_key
    output logic [1:0]                         m_tuser,  // found, evicted
    // capacity register
    input  logic                               cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wr_data
);
    import lkvc_pkg::*;

    // control and configuration
    state_t           state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // captured request
    logic             req_set_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [VAL_W-1:0] req_val_reg;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             out_found_reg, out_evicted_reg;
    logic [RD_W-1:0]  out_rd_reg;
    logic [KEY_W-1:0] out_evk_reg;

    // chain signals
    entry_t             cell_q   [ENTRIES];
    entry_t             cell_up  [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] load_vec;
    logic [ENTRIES-1:0] valid_vec;
    entry_t             new_entry;

    // lookup results
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;
    logic [VAL_W-1:0] hit_val;
    logic [CMP_W-1:0] cap_eff;
    logic [CMP_W-1:0] cnt_ext;
    logic [IDX_W-1:0] cnt_m1;
    logic [IDX_W-1:0] pos;
    logic             evict;
    logic             update;
    logic             do_shift;
    logic             out_free;
    logic             accept;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state: wait in lookup until the output register can take the result
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        update     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // no request taken while in reset
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    update     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // request capture, payload only
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_set_reg <= s_tuser;
            req_key_reg <= s_tdata[KEY_W-1:0];
            req_val_reg <= s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    // effective capacity: 0 acts as 1, clamp to the number of cells
    always_comb begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_eff > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    // hit detection: at most one cell matches, priority kept for safety
    always_comb begin
        hit_idx = '0;
        hit_val = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            hit_val = hit_val | (cell_q[i].value & {VAL_W{match_vec[i]}});
        end
    end

    assign hit_any = |match_vec;
    assign cnt_ext = CMP_W'(cnt_reg);
    assign cnt_m1  = IDX_W'(cnt_reg - CNT_W'(1));
    assign evict   = req_set_reg && !hit_any && (cnt_ext >= cap_eff) && (cnt_reg != '0);

    // shift depth: the hit slot, the slot of the evicted entry, or the first free slot
    always_comb begin
        if (hit_any) begin
            pos = hit_idx;
        end else if (evict) begin
            pos = cnt_m1;
        end else begin
            pos = IDX_W'(cnt_reg);
        end
    end

    // get miss leaves the chain untouched
    assign do_shift = update && (hit_any || req_set_reg);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            load_vec[i]  = do_shift && (IDX_W'(i) <= pos);
            valid_vec[i] = cell_q[i].valid;
        end
    end

    // the entry that becomes most recently used
    assign new_entry.valid = 1'b1;
    assign new_entry.key   = req_key_reg;
    assign new_entry.value = req_set_reg ? req_val_reg : hit_val;

    // chain of cells, slot 0 most recently used
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_up[g] = new_entry;
        end else begin : g_link
            assign cell_up[g] = cell_q[g-1];
        end
        lkvc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .load    (load_vec[g]),
            .up      (cell_up[g]),
            .cmp_key (req_key_reg),
            .q       (cell_q[g]),
            .match   (match_vec[g])
        );
    end

    // entry count: grows only on an insert without eviction
    always_comb begin
        cnt_next = cnt_reg;
        if (update && req_set_reg && !hit_any && !evict) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (update) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            out_found_reg   <= hit_any;
            out_evicted_reg <= evict;
            // set returns 0, get miss returns -1
            if (req_set_reg) begin
                out_rd_reg <= '0;
            end else if (hit_any) begin
                out_rd_reg <= RD_W'(hit_val);
            end else begin
                out_rd_reg <= '1;
            end
            out_evk_reg <= evict ? cell_q[cnt_m1].key : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {out_evicted_reg, out_found_reg};
    assign m_tdata  = M_DATA_W'({out_evk_reg, out_rd_reg});

    // checks
    `LKVC_ASSERT_NOW(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(ENTRIES),
        "entry count above number of cells")
    `LKVC_ASSERT_NOW(a_valid_prefix, aclk, aresetn, 1'b1,
        $countones(valid_vec) == int'(cnt_reg), "valid cells disagree with entry count")
    `LKVC_ASSERT_NOW(a_single_hit, aclk, aresetn, state_reg == ST_LOOKUP,
        $onehot0(match_vec), "key held in more than one cell")
    `LKVC_ASSERT_NEXT(a_evict_miss, aclk, aresetn, update && evict,
        m_tvalid && !m_tuser[0], "eviction reported with a hit")

endmodule
